/* rtl/core/eim_pkg.sv */
// ----------------------------------------------------------------------------
// eim_pkg
// Shared types and constants of the extent interval map.
// ----------------------------------------------------------------------------
package eim_pkg;

    localparam int MAX_EXTENTS_DEF = 32;
    localparam int RESULT_CAP      = 32;
    localparam int CAP_W           = $clog2(RESULT_CAP + 1);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_QUERY  = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    typedef struct packed {
        logic [31:0] location;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] start;
    } t_entry;

    typedef struct packed {
        logic [31:0] location;
        logic [31:0] offset;
        logic [31:0] length;
    } t_piece;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_WAIT,
        ST_P1_EVAL,
        ST_HOLE,
        ST_NEW,
        ST_P2_WAIT,
        ST_P2_EVAL,
        ST_Q_WAIT,
        ST_Q_EVAL,
        ST_Q_END,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic idx_clr;
        logic clear;
        logic p1_push;
        logic hole_push;
        logic new_push;
        logic p2_push;
        logic commit;
        logic q_eval;
        logic q_final;
        logic ack;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       cap_hit;
        logic       q_hit;
        logic       pend_v;
        logic       out_free;
        logic [1:0] in_func;
        logic       in_len_zero;
    } t_sts;

endpackage

/* rtl/core/eim_ram.sv */
// ----------------------------------------------------------------------------
// eim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eim_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/eim_datapath.sv */
// ----------------------------------------------------------------------------
// eim_datapath
// Extent table banks, scan index, piece arithmetic and result register.
// ----------------------------------------------------------------------------
module eim_datapath #(
    parameter int MAX_EXTENTS = eim_pkg::MAX_EXTENTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_func,
    input  logic [31:0]   i_range_start,
    input  logic [31:0]   i_range_length,
    input  logic [31:0]   i_new_location,
    input  logic          i_stall,
    input  eim_pkg::t_cmd i_cmd,
    output eim_pkg::t_sts o_sts,
    output logic          o_valid,
    output logic [31:0]   o_piece_location,
    output logic [31:0]   o_piece_offset,
    output logic [31:0]   o_piece_length,
    output logic          o_piece_valid,
    output logic          o_last_piece,
    output logic          o_status
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = $bits(eim_pkg::t_entry);

    logic [31:0]             r_s;
    logic [32:0]             r_e;
    logic [31:0]             r_loc;
    logic [32:0]             r_tend;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_n;
    logic                    r_ovf;
    logic                    r_bank;
    logic                    r_status;
    logic [eim_pkg::CAP_W-1:0] r_k;
    logic                    r_pend_v;
    eim_pkg::t_piece         r_pend;
    logic                    r_o_valid;
    eim_pkg::t_piece         r_o_piece;
    logic                    r_o_pv;
    logic                    r_o_last;
    logic                    r_o_status;

    logic [EW-1:0]   w_q0;
    logic [EW-1:0]   w_q1;
    eim_pkg::t_entry w_ent;
    eim_pkg::t_entry w_wr;
    logic            w_push;
    logic            w_we;
    logic [32:0]     w_a;
    logic [32:0]     w_b;
    logic [32:0]     w_s33;
    logic [32:0]     w_sum;
    logic [32:0]     w_l_hi;
    logic [32:0]     w_l_len;
    logic [32:0]     w_ns;
    logic [32:0]     w_ns_d;
    logic [32:0]     w_r_len;
    logic [32:0]     w_n_len;
    logic [32:0]     w_lo;
    logic [32:0]     w_hi;
    logic [32:0]     w_lo_d;
    logic [32:0]     w_q_len;
    logic            w_hit;
    eim_pkg::t_piece w_qp;
    logic            w_out_free;

    assign w_ent   = eim_pkg::t_entry'(r_bank ? w_q1 : w_q0);
    assign w_a     = {1'b0, w_ent.start};
    assign w_b     = w_a + {1'b0, w_ent.length};
    assign w_s33   = {1'b0, r_s};
    assign w_sum   = {1'b0, i_range_start} + {1'b0, i_range_length};
    assign w_l_hi  = (w_b < w_s33) ? w_b : w_s33;
    assign w_l_len = w_l_hi - w_a;
    assign w_ns    = (w_a > r_e) ? w_a : r_e;
    assign w_ns_d  = w_ns - w_a;
    assign w_r_len = w_b - w_ns;
    assign w_n_len = r_e - w_s33;
    assign w_lo    = (w_a > w_s33) ? w_a : w_s33;
    assign w_hi    = (w_b < r_e) ? w_b : r_e;
    assign w_lo_d  = w_lo - w_a;
    assign w_q_len = w_hi - w_lo;
    assign w_hit   = w_lo < w_hi;

    assign w_qp.location = w_ent.location;
    assign w_qp.offset   = w_ent.offset + w_lo_d[31:0];
    assign w_qp.length   = w_q_len[31:0];

    always_comb begin
        w_push = 1'b0;
        w_wr   = '0;
        priority if (i_cmd.p1_push) begin
            w_push = w_a < w_s33;
            w_wr   = '{location: w_ent.location, offset: w_ent.offset,
                       length: w_l_len[31:0], start: w_ent.start};
        end else if (i_cmd.hole_push) begin
            w_push = w_s33 > r_tend;
            w_wr   = '{location: 32'd0, offset: 32'd0,
                       length: r_s - r_tend[31:0], start: r_tend[31:0]};
        end else if (i_cmd.new_push) begin
            w_push = 1'b1;
            w_wr   = '{location: r_loc, offset: 32'd0,
                       length: w_n_len[31:0], start: r_s};
        end else if (i_cmd.p2_push) begin
            w_push = w_b > r_e;
            w_wr   = '{location: w_ent.location, offset: w_ent.offset + w_ns_d[31:0],
                       length: w_r_len[31:0], start: w_ns[31:0]};
        end else begin
            w_push = 1'b0;
        end
    end

    assign w_we       = w_push && (r_n < CW'(MAX_EXTENTS));
    assign w_out_free = !r_o_valid || !i_stall;

    eim_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we && r_bank),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (w_wr),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_q0)
    );

    eim_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we && !r_bank),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (w_wr),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_q1)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s   <= i_range_start;
            r_e   <= w_sum[32] ? {1'b1, 32'd0} : w_sum;
            r_loc <= i_new_location;
        end
        if (i_cmd.q_eval && w_hit) begin
            r_pend <= w_qp;
        end
        if (i_cmd.p1_push) begin
            r_tend <= w_b;
        end else if (i_cmd.load) begin
            r_tend <= '0;
        end
        if (i_cmd.q_eval && w_hit && r_pend_v) begin
            r_o_piece  <= r_pend;
            r_o_pv     <= 1'b1;
            r_o_last   <= 1'b0;
            r_o_status <= 1'b0;
        end else if (i_cmd.q_final) begin
            r_o_piece  <= r_pend_v ? r_pend : '0;
            r_o_pv     <= r_pend_v;
            r_o_last   <= 1'b1;
            r_o_status <= 1'b0;
        end else if (i_cmd.ack) begin
            r_o_piece  <= '0;
            r_o_pv     <= 1'b0;
            r_o_last   <= 1'b1;
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_n       <= '0;
            r_ovf     <= 1'b0;
            r_bank    <= 1'b0;
            r_status  <= 1'b0;
            r_k       <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_n      <= '0;
                r_ovf    <= 1'b0;
                r_status <= 1'b0;
                r_k      <= '0;
                r_pend_v <= 1'b0;
            end else begin
                if (w_we) begin
                    r_n <= r_n + 1'b1;
                end else if (w_push) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.q_eval && w_hit) begin
                    r_k      <= r_k + 1'b1;
                    r_pend_v <= 1'b1;
                end
                if (i_cmd.commit) begin
                    if (r_ovf) begin
                        r_status <= 1'b1;
                    end else begin
                        r_bank  <= !r_bank;
                        r_count <= r_n;
                    end
                end
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end
            if ((i_cmd.q_eval && w_hit && r_pend_v) || i_cmd.q_final || i_cmd.ack) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.scan_done   = r_idx == r_count;
    assign o_sts.cap_hit     = r_k == eim_pkg::CAP_W'(eim_pkg::RESULT_CAP);
    assign o_sts.q_hit       = w_hit;
    assign o_sts.pend_v      = r_pend_v;
    assign o_sts.out_free    = w_out_free;
    assign o_sts.in_func     = i_func;
    assign o_sts.in_len_zero = i_range_length == 32'd0;

    assign o_valid          = r_o_valid;
    assign o_piece_location = r_o_piece.location;
    assign o_piece_offset   = r_o_piece.offset;
    assign o_piece_length   = r_o_piece.length;
    assign o_piece_valid    = r_o_pv;
    assign o_last_piece     = r_o_last;
    assign o_status         = r_o_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS)) else $error("extent count beyond table size");
    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_k != '0)) else $error("pending piece without count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.q_eval && w_hit && r_pend_v) || i_cmd.q_final || i_cmd.ack) |-> w_out_free)
        else $error("result register overwritten while held");
    a_commit_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_ovf) |=> (r_count == $past(r_n)))
        else $error("commit lost table size");

endmodule

/* rtl/core/eim_ctrl.sv */
// ----------------------------------------------------------------------------
// eim_ctrl
// Sequencer for insert scans, query scans and responses.
// ----------------------------------------------------------------------------
module eim_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  eim_pkg::t_sts i_sts,
    output eim_pkg::t_cmd o_cmd,
    output logic          o_stall
);

    eim_pkg::t_state r_state;
    eim_pkg::t_state n_state;
    logic            w_q_emit_ok;

    assign w_q_emit_ok = !(i_sts.q_hit && i_sts.pend_v) || i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eim_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eim_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_sts.in_func == eim_pkg::FN_QUERY) begin
                        n_state = eim_pkg::ST_Q_WAIT;
                    end else if (i_sts.in_func == eim_pkg::FN_INSERT && !i_sts.in_len_zero) begin
                        n_state = eim_pkg::ST_P1_WAIT;
                    end else begin
                        n_state = eim_pkg::ST_RESP;
                    end
                end
            end
            eim_pkg::ST_P1_WAIT: n_state = i_sts.scan_done ? eim_pkg::ST_HOLE
                                                           : eim_pkg::ST_P1_EVAL;
            eim_pkg::ST_P1_EVAL: n_state = eim_pkg::ST_P1_WAIT;
            eim_pkg::ST_HOLE:    n_state = eim_pkg::ST_NEW;
            eim_pkg::ST_NEW:     n_state = eim_pkg::ST_P2_WAIT;
            eim_pkg::ST_P2_WAIT: n_state = i_sts.scan_done ? eim_pkg::ST_RESP
                                                           : eim_pkg::ST_P2_EVAL;
            eim_pkg::ST_P2_EVAL: n_state = eim_pkg::ST_P2_WAIT;
            eim_pkg::ST_Q_WAIT:  n_state = (i_sts.scan_done || i_sts.cap_hit) ?
                                           eim_pkg::ST_Q_END : eim_pkg::ST_Q_EVAL;
            eim_pkg::ST_Q_EVAL: begin
                if (w_q_emit_ok) begin
                    n_state = eim_pkg::ST_Q_WAIT;
                end
            end
            eim_pkg::ST_Q_END, eim_pkg::ST_RESP: begin
                if (i_sts.out_free) begin
                    n_state = eim_pkg::ST_IDLE;
                end
            end
            default: n_state = eim_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            eim_pkg::ST_IDLE: begin
                o_cmd.load  = i_valid;
                o_cmd.clear = i_valid && (i_sts.in_func == eim_pkg::FN_CLEAR);
            end
            eim_pkg::ST_P1_EVAL: begin
                o_cmd.p1_push = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            eim_pkg::ST_HOLE: o_cmd.hole_push = 1'b1;
            eim_pkg::ST_NEW: begin
                o_cmd.new_push = 1'b1;
                o_cmd.idx_clr  = 1'b1;
            end
            eim_pkg::ST_P2_WAIT: o_cmd.commit = i_sts.scan_done;
            eim_pkg::ST_P2_EVAL: begin
                o_cmd.p2_push = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            eim_pkg::ST_Q_EVAL: begin
                o_cmd.q_eval  = w_q_emit_ok;
                o_cmd.idx_inc = w_q_emit_ok;
            end
            eim_pkg::ST_Q_END: o_cmd.q_final = i_sts.out_free;
            eim_pkg::ST_RESP:  o_cmd.ack     = i_sts.out_free;
            default:           o_cmd = '0;
        endcase
    end

    assign o_stall = r_state != eim_pkg::ST_IDLE;

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != eim_pkg::ST_IDLE)) else $error("accepted item dropped");
    a_one_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.p1_push, o_cmd.hole_push, o_cmd.new_push, o_cmd.p2_push}))
        else $error("conflicting table writes");
    a_hole_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hole_push |=> o_cmd.new_push) else $error("new extent not written after gap");

endmodule

/* rtl/core/extent_interval_map.sv */
// ----------------------------------------------------------------------------
// extent_interval_map
// Address-sorted extent table with overwrite insert, range query and clear.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   func, range_start, range_length,
//                                           new_location
//   output   out        o_valid / i_stall   piece_location/offset/length,
//                                           piece_valid, last_piece, status
//
// One item at a time. Insert: a first scan of the stored entries, the gap and
// new writes, a second scan of the entries, then commit. Query: one scan of
// the entries, held by output stalls. Clear: a direct response. The entry scan
// through the registered-read table banks paces inserts and queries.
// Reset empties the table at once. Output stalls hold the scan when a piece
// is waiting to leave the result register.
// ----------------------------------------------------------------------------
module extent_interval_map #(
    parameter int MAX_EXTENTS = eim_pkg::MAX_EXTENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_range_start,
    input  logic [31:0] i_range_length,
    input  logic [31:0] i_new_location,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_piece_location,
    output logic [31:0] o_piece_offset,
    output logic [31:0] o_piece_length,
    output logic        o_piece_valid,
    output logic        o_last_piece,
    output logic        o_status
);

    eim_pkg::t_cmd w_cmd;
    eim_pkg::t_sts w_sts;

    eim_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    eim_datapath #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_func           (i_func),
        .i_range_start    (i_range_start),
        .i_range_length   (i_range_length),
        .i_new_location   (i_new_location),
        .i_stall          (i_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .o_piece_location (o_piece_location),
        .o_piece_offset   (o_piece_offset),
        .o_piece_length   (o_piece_length),
        .o_piece_valid    (o_piece_valid),
        .o_last_piece     (o_last_piece),
        .o_status         (o_status)
    );

endmodule

/* verif/extent_interval_map_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_interval_map_test
// Drives insert, query and clear transfers into the extent table, predicts
// every answer with a software copy of the sorted table, and compares each
// output transfer field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module extent_interval_map_test;

    localparam int NX = eim_pkg::MAX_EXTENTS_DEF;
    localparam int TMAX = 2 * NX + 2;
    localparam logic [1:0] FN_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] rstart;
        logic [31:0] rlen;
        logic [31:0] loc;
    } t_op;

    typedef struct {
        logic [31:0] loc;
        logic [31:0] off;
        logic [31:0] len;
        logic        pv;
        logic        last;
        logic        st;
    } t_ans;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  in_func = '0;
    logic [31:0] in_start = '0, in_len = '0, in_loc = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] o_loc, o_off, o_len;
    logic        o_pv, o_last, o_st;

    t_op  op_queue[$];
    t_ans ans_queue[$];
    int   errors = 0;
    int   n_pieces = 0;
    int   n_full = 0;
    bit   calm = 1'b0;
    bit   hold_out = 1'b0;
    bit   drain_pause = 1'b0;

    logic [31:0] tb_start[NX], tb_len[NX], tb_off[NX], tb_loc[NX];
    int          tb_count = 0;

    extent_interval_map dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(in_func), .i_range_start(in_start), .i_range_length(in_len),
        .i_new_location(in_loc), .o_valid(out_valid), .i_stall(out_stall),
        .o_piece_location(o_loc), .o_piece_offset(o_off), .o_piece_length(o_len),
        .o_piece_valid(o_pv), .o_last_piece(o_last), .o_status(o_st)
    );

    always #4 clk = ~clk;

    function automatic t_ans mk(logic [31:0] l, logic [31:0] o, logic [31:0] n,
                                logic pv, logic last, logic st);
        t_ans a;
        a.loc = l; a.off = o; a.len = n; a.pv = pv; a.last = last; a.st = st;
        return a;
    endfunction

    task automatic map_insert(logic [63:0] s, logic [63:0] n, logic [31:0] loc,
                              output logic st);
        logic [31:0] ts[TMAX], tl[TMAX], to[TMAX], tc[TMAX];
        int          k;
        logic [63:0] e, tend, a, b, hi, ns;
        k = 0;
        st = 1'b0;
        tend = '0;
        if (n == 0) return;
        e = s + n;
        if (e > 64'h1_0000_0000) e = 64'h1_0000_0000;
        if (tb_count > 0) tend = 64'(tb_start[tb_count-1]) + 64'(tb_len[tb_count-1]);
        for (int i = 0; i < tb_count; i++) begin
            a = 64'(tb_start[i]); b = a + 64'(tb_len[i]);
            if (a < s) begin
                hi = (b < s) ? b : s;
                ts[k] = 32'(a); tl[k] = 32'(hi - a); to[k] = tb_off[i]; tc[k] = tb_loc[i];
                k++;
            end
        end
        if (s > tend) begin
            ts[k] = 32'(tend); tl[k] = 32'(s - tend); to[k] = '0; tc[k] = '0; k++;
        end
        ts[k] = 32'(s); tl[k] = 32'(e - s); to[k] = '0; tc[k] = loc; k++;
        for (int i = 0; i < tb_count; i++) begin
            a = 64'(tb_start[i]); b = a + 64'(tb_len[i]);
            if (b > e) begin
                ns = (a > e) ? a : e;
                ts[k] = 32'(ns); tl[k] = 32'(b - ns); to[k] = tb_off[i] + 32'(ns - a);
                tc[k] = tb_loc[i]; k++;
            end
        end
        if (k > NX) begin
            st = 1'b1;
            return;
        end
        for (int i = 0; i < k; i++) begin
            tb_start[i] = ts[i]; tb_len[i] = tl[i]; tb_off[i] = to[i]; tb_loc[i] = tc[i];
        end
        tb_count = k;
    endtask

    task automatic map_apply(t_op op);
        logic [63:0] s, e, a, b, lo, hi;
        logic        st;
        int          k;
        s = 64'(op.rstart);
        k = 0;
        if (op.func == eim_pkg::FN_QUERY) begin
            if (op.rlen != 0) begin
                e = s + 64'(op.rlen);
                if (e > 64'h1_0000_0000) e = 64'h1_0000_0000;
                for (int i = 0; i < tb_count && k < eim_pkg::RESULT_CAP; i++) begin
                    a = 64'(tb_start[i]); b = a + 64'(tb_len[i]);
                    lo = (a > s) ? a : s;
                    hi = (b < e) ? b : e;
                    if (lo < hi) begin
                        ans_queue.insert(ans_queue.size(),
                                         mk(tb_loc[i], tb_off[i] + 32'(lo - a),
                                            32'(hi - lo), 1'b1, 1'b0, 1'b0));
                        k++;
                    end
                end
            end
            if (k == 0) ans_queue.insert(ans_queue.size(),
                                         mk('0, '0, '0, 1'b0, 1'b1, 1'b0));
            else ans_queue[$].last = 1'b1;
            n_pieces += k;
        end else begin
            st = 1'b0;
            if (op.func == eim_pkg::FN_INSERT) map_insert(s, 64'(op.rlen), op.loc, st);
            else if (op.func == eim_pkg::FN_CLEAR) tb_count = 0;
            if (st) n_full++;
            ans_queue.insert(ans_queue.size(), mk('0, '0, '0, 1'b0, 1'b1, st));
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic add(logic [1:0] f, logic [31:0] s, logic [31:0] n, logic [31:0] l);
        t_op op;
        op.func = f; op.rstart = s; op.rlen = n; op.loc = l;
        op_queue.insert(op_queue.size(), op);
    endtask

    // sender
    int in_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                map_apply(op_queue.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    in_gap <= int'($urandom_range(0, 17));
                    in_valid <= 1'b0;
                end else if (drain_pause || op_queue.size() == 0) begin
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_func <= op_queue[0].func;
                    in_start <= op_queue[0].rstart;
                    in_len <= op_queue[0].rlen;
                    in_loc <= op_queue[0].loc;
                end
            end
        end
    end

    // receiver
    int out_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (ans_queue.size() == 0) begin
                    report("unexpected transfer", '0, '0);
                end else begin
                    automatic t_ans w = ans_queue.pop_front();
                    if (o_loc !== w.loc) report("piece_location", o_loc, w.loc);
                    if (o_off !== w.off) report("piece_offset", o_off, w.off);
                    if (o_len !== w.len) report("piece_length", o_len, w.len);
                    if (o_pv !== w.pv) report("piece_valid", 32'(o_pv), 32'(w.pv));
                    if (o_last !== w.last) report("last_piece", 32'(o_last), 32'(w.last));
                    if (o_st !== w.st) report("status", 32'(o_st), 32'(w.st));
                end
            end
            if (hold_out) begin
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap <= int'($urandom_range(0, 17));
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drain();
        while (op_queue.size() > 0 || in_valid || ans_queue.size() > 0) @(posedge clk);
    endtask

    task automatic rnd_op();
        int          r;
        logic [31:0] s, n;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) begin
            s = $urandom(); n = $urandom();
        end else begin
            s = $urandom_range(0, 4000);
            n = $urandom_range(1, 300);
        end
        if ($urandom_range(0, 30) == 0) n = '0;
        if (r < 55) add(eim_pkg::FN_INSERT, s, n, $urandom());
        else if (r < 93) add(eim_pkg::FN_QUERY, s, n, $urandom());
        else if (r < 97) add(eim_pkg::FN_CLEAR, s, n, $urandom());
        else add(FN_SPARE, s, n, $urandom());
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        add(eim_pkg::FN_QUERY, '0, 32'hFFFF_FFFF, '0);
        add(eim_pkg::FN_INSERT, 32'd100, 32'd50, 32'hAAAA_5555);
        add(eim_pkg::FN_INSERT, '0, '0, 32'd7);
        add(eim_pkg::FN_INSERT, 32'd120, 32'd10, 32'h5555_AAAA);
        add(eim_pkg::FN_INSERT, 32'd90, 32'd20, 32'd3);
        add(eim_pkg::FN_INSERT, 32'd95, 32'd60, 32'd4);
        add(eim_pkg::FN_QUERY, '0, 32'd1000, '0);
        add(eim_pkg::FN_QUERY, 32'd97, 32'd5, '0);
        add(eim_pkg::FN_QUERY, 32'd500, 32'd10, '0);
        add(eim_pkg::FN_QUERY, 32'd10, '0, '0);
        add(eim_pkg::FN_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add(eim_pkg::FN_QUERY, 32'hFFFF_FFF8, 32'hFFFF_FFFF, '0);
        add(FN_SPARE, 32'd1, 32'd2, 32'd3);
        add(eim_pkg::FN_CLEAR, '0, '0, '0);
        add(eim_pkg::FN_QUERY, '0, 32'd100, '0);
        add(eim_pkg::FN_INSERT, '0, 32'hFFFF_FFFF, 32'h8000_0001);
        add(eim_pkg::FN_INSERT, 32'h8000_0000, 32'd16, 32'd9);
        add(eim_pkg::FN_QUERY, 32'h7FFF_FFF0, 32'd64, '0);
        add(eim_pkg::FN_CLEAR, '0, '0, '0);
        for (int i = 0; i < 40; i++) add(eim_pkg::FN_INSERT, 32'(i * 4), 32'd2, 32'(i + 1));
        add(eim_pkg::FN_QUERY, '0, 32'd1000, '0);
        wait_drain();
        for (int i = 0; i < 30; i++) rnd_op();
        // long receiver hold while items keep coming
        hold_out = 1'b1;
        for (int i = 0; i < 6; i++) add(eim_pkg::FN_QUERY, '0, 32'd5000, '0);
        repeat (600) @(posedge clk);
        hold_out = 1'b0;
        wait_drain();
        drain_pause = 1'b1;
        repeat (20) @(posedge clk);
        drain_pause = 1'b0;
        add(eim_pkg::FN_CLEAR, '0, '0, '0);
        for (int i = 0; i < 10; i++) rnd_op();
        wait_drain();
        calm = 1'b1;
        for (int i = 0; i < 25; i++) rnd_op();
        wait_drain();
        repeat (300) @(posedge clk);
        $display("covered inserts, queries, clears and the spare code; %0d pieces returned,",
                 n_pieces);
        $display("%0d inserts refused on a full table, with stalls on both sides", n_full);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
